// ----- rtl/opc_pkg.sv -----
// Package for the OPc derivation block: payload structs, AES S-box and helpers.
// No dependencies.
package opc_pkg;

  localparam int unsigned NumRounds = 10;

  typedef enum logic [1:0] {
    CFG_OP_HIGH = 2'd0,
    CFG_OP_LOW  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] ki_high;
    logic [63:0] ki_low;
  } opc_in_t;

  typedef struct packed {
    logic [63:0] opc_high;
    logic [63:0] opc_low;
  } opc_out_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block sits in bits [127-8i -: 8].
  function automatic logic [7:0] byte_at(input logic [127:0] b, input int unsigned i);
    return b[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] rk, input logic [7:0] rcon);
    logic [127:0] o;
    logic [31:0]  t;
    t = {sbox(byte_at(rk, 13)) ^ rcon, sbox(byte_at(rk, 14)),
         sbox(byte_at(rk, 15)), sbox(byte_at(rk, 12))};
    o[127:96] = rk[127:96] ^ t;
    o[95:64]  = rk[95:64] ^ o[127:96];
    o[63:32]  = rk[63:32] ^ o[95:64];
    o[31:0]   = rk[31:0] ^ o[63:32];
    return o;
  endfunction

  // SubBytes, ShiftRows and optionally MixColumns.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(c*4+r) -: 8] = sbox(byte_at(s, ((c + r) % 4) * 4 + r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(t, 4*c);
      a1 = byte_at(t, 4*c+1);
      a2 = byte_at(t, 4*c+2);
      a3 = byte_at(t, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                           a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    return mix ? m : t;
  endfunction

endpackage

// ----- rtl/opc_derivation_aes128.sv -----
// OPc derivation top level: ten-stage unrolled AES-128 with per-item key expansion.
// Depends on opc_pkg.
//
// Computes OPc = AES128(Ki, OP) xor OP. OP is written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// (index 0 = op_high, 1 = op_low, others ignored); the user must write OP only while
// the block is idle, which the block itself does not enforce. Each request carries Ki;
// one AES round and one key-expansion step sit in each of ten pipeline stages, so a new
// request is taken every cycle unless every stage is full and the output side stalls.
// Stall freezes the whole pipe only then; bubbles are squeezed out otherwise.
module opc_derivation_aes128
  import opc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  opc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output opc_out_t    out_data_o
);

  logic [127:0] op_q;
  logic [NumRounds-1:0] vld_q;
  logic [127:0] st_q [NumRounds];
  logic [127:0] rk_q [NumRounds];
  logic [7:0]   rcon_c [NumRounds];
  logic [NumRounds-1:0] adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OP_HIGH: op_q[127:64] <= cfg_wdata_i;
        CFG_OP_LOW:  op_q[63:0]   <= cfg_wdata_i;
        default:     op_q <= op_q;
      endcase
    end
  end

  // Stage k may load when it is empty or its own content moves on.
  always_comb begin
    adv[NumRounds-1] = !vld_q[NumRounds-1] || !out_stall_i;
    for (int k = NumRounds-2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    rcon_c[0] = 8'h01;
    for (int k = 1; k < NumRounds; k++) begin
      rcon_c[k] = xtime(rcon_c[k-1]);
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumRounds; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rk_q[0] <= next_key({in_data_i.ki_high, in_data_i.ki_low}, rcon_c[0]);
      st_q[0] <= aes_round(op_q ^ {in_data_i.ki_high, in_data_i.ki_low}, 1'b1);
    end
    for (int k = 1; k < NumRounds; k++) begin
      if (adv[k]) begin
        rk_q[k] <= next_key(rk_q[k-1], rcon_c[k]);
        st_q[k] <= aes_round(st_q[k-1] ^ rk_q[k-1], (k != NumRounds-1));
      end
    end
  end

  assign out_valid_o = vld_q[NumRounds-1];
  assign out_data_o  = st_q[NumRounds-1] ^ rk_q[NumRounds-1] ^ op_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q) && out_stall_i)
    else $error("input stalled with room in pipe");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumRounds-2] && !out_stall_i |=> out_valid_o)
    else $error("item lost in last stage");

endmodule

// ----- verif/tb_opc_derivation_aes128.sv -----
// Testbench for opc_derivation_aes128: random and directed Ki requests checked against
// a behavioral OPc predictor (AES-128 of OP under Ki, xor OP). Depends on opc_pkg.
`timescale 1ns / 1ps
module tb_opc_derivation_aes128;
  import opc_pkg::*;

  localparam int unsigned PipeDepth  = 10;
  localparam int unsigned NumRandom  = 1850;
  localparam int unsigned CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  opc_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  opc_out_t    out_data_o;

  opc_derivation_aes128 u_dut (.*);

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Predictor copy of the operator constant.
  logic [63:0] op_hi_q, op_lo_q;

  opc_in_t  pending_keys[$];
  opc_out_t expected_opc[$];
  bit       failed;
  bit       hold_send;
  int       cycles;

  logic [7:0] sb_tab[256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf2(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Bytes are kept as an array, byte 0 = most significant of the 128-bit word.
  function automatic opc_out_t derive_opc(opc_in_t ki, logic [63:0] oph, logic [63:0] opl);
    logic [7:0]   rk[16], st[16], tmp[16], w[4];
    logic [7:0]   rcon, a0, a1, a2, a3, al;
    logic [127:0] kv, ov, res;
    kv = {ki.ki_high, ki.ki_low};
    ov = {oph, opl};
    for (int i = 0; i < 16; i++) begin
      rk[i] = kv[127-8*i -: 8];
      st[i] = ov[127-8*i -: 8] ^ rk[i];
    end
    rcon = 8'h01;
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // key schedule step
      w[0] = sb_tab[rk[13]] ^ rcon;
      w[1] = sb_tab[rk[14]];
      w[2] = sb_tab[rk[15]];
      w[3] = sb_tab[rk[12]];
      for (int i = 0; i < 16; i++) rk[i] = rk[i] ^ ((i < 4) ? w[i] : rk[i-4]);
      rcon = gf2(rcon);
      // SubBytes + ShiftRows
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[c*4+r] = sb_tab[st[((c+r)%4)*4+r]];
      st = tmp;
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ gf2(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ gf2(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ gf2(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ gf2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i] ^ ov[127-8*i -: 8];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 64'h1 << $urandom_range(0, 63);
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  // Driver: one request at a time, random gap after each, held while stalled.
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_opc.push_back(derive_opc(in_data_i, op_hi_q, op_lo_q));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_keys.size() > 0 && !hold_send) begin
          in_data_i  <= pending_keys.pop_front();
          in_valid_i <= 1'b1;
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall, compares each accepted result with the oldest expectation.
  int stall_left;
  opc_out_t exp_v;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_opc.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          failed = 1'b1;
        end else begin
          exp_v = expected_opc.pop_front();
          if (out_data_o.opc_high !== exp_v.opc_high) begin
            $display("%0t: opc_high exp %h got %h", $time, exp_v.opc_high,
                     out_data_o.opc_high);
            failed = 1'b1;
          end
          if (out_data_o.opc_low !== exp_v.opc_low) begin
            $display("%0t: opc_low exp %h got %h", $time, exp_v.opc_low,
                     out_data_o.opc_low);
            failed = 1'b1;
          end
        end
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        if (!(out_valid_o && !out_stall_i)) stall_left <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_keys.size() > 0 || in_valid_i || expected_opc.size() > 0)
      @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  // Register write while idle; the predictor copy follows the same rule.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == 2'(CFG_OP_HIGH)) op_hi_q = val;
    else if (idx == 2'(CFG_OP_LOW)) op_lo_q = val;
  endtask

  task automatic push_key(logic [63:0] hi, logic [63:0] lo);
    opc_in_t k;
    k.ki_high = hi;
    k.ki_low  = lo;
    pending_keys.push_back(k);
  endtask

  initial begin
    failed      = 1'b0;
    hold_send   = 1'b0;
    op_hi_q     = '0;
    op_lo_q     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // OP never written: reset value of zero.
    push_key('0, '0);
    push_key('1, '1);
    push_key(64'h8000_0000_0000_0000, 64'h1);
    wait_drained();

    // Known Milenage test set 1 OP, then extremes.
    write_reg(CFG_OP_HIGH, 64'hcdc202d5123e20f6);
    write_reg(CFG_OP_LOW, 64'h2b6d676ac72cb318);
    push_key(64'h465b5ce8b199b49f, 64'haa5f0a2ee238a6bc);
    push_key('0, '1);
    push_key('1, '0);
    push_key(64'h0123456789abcdef, 64'hfedcba9876543210);
    wait_drained();
    write_reg(CFG_OP_HIGH, '1);
    write_reg(CFG_OP_LOW, '1);
    push_key('0, '0);
    push_key('1, '1);
    wait_drained();

    // Random phases with several OP settings; each phase drains before rewriting OP.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_OP_HIGH, (ph == 0) ? 64'h0 : rand64());
      write_reg(CFG_OP_LOW, (ph == 0) ? 64'h0 : rand64());
      // The write below has no effect on the predictor or the block.
      if (ph == 2) write_reg(2'd2, 64'hdead_beef_dead_beef);
      for (int n = 0; n < NumRandom / 6; n++) push_key(rand64(), rand64());
      if (ph == 3) begin
        // Hold the sender until every result has come, then resume.
        while (pending_keys.size() > NumRandom / 12) @(posedge clk_i);
        hold_send = 1'b1;
        while (in_valid_i || expected_opc.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      wait_drained();
    end

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
